/* hdl/salted_hash_find_or_insert_macros.svh */
// ----------------------------------------------------------------------------
// Salted hash find-or-insert: assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SALTED_HASH_FIND_OR_INSERT_MACROS_SVH
`define SALTED_HASH_FIND_OR_INSERT_MACROS_SVH
`ifndef SYNTH
`define SHFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shfi assertion failed");
`define SHFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shfi assertion failed");
`else
`define SHFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/shfi_pkg.sv */
// ----------------------------------------------------------------------------
// Salted hash find-or-insert: package
// Widths, op codes and memory request types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none
package shfi_pkg;

    localparam int SLOT_AW        = 12;
    localparam int TABLE_SLOTS    = 1 << SLOT_AW;
    localparam int ROW_W          = 12;
    localparam int MAX_ROWS       = 1 << ROW_W;
    localparam int KEY_W          = 64;
    localparam int HASH_W         = 64;
    localparam int SALT_W         = 16;
    localparam int SALT_LSB       = 48;
    localparam int STEP_LSB       = 59;
    localparam int STEP_W         = HASH_W - STEP_LSB;
    localparam int OP_W           = 2;
    localparam int CAP_LOG2_W     = 4;
    localparam int CAP_LOG2_MIN   = 5;
    localparam int CAP_LOG2_MAX   = SLOT_AW;
    localparam int CAP_LOG2_RESET = 12;
    localparam int CNT_W          = SLOT_AW + 1;

    typedef enum logic [OP_W-1:0] {
        OP_FIND_INSERT = 2'd0,
        OP_PLACE       = 2'd1,
        OP_CLEAR       = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    typedef struct packed {
        logic              valid;
        logic [SALT_W-1:0] salt;
        logic [ROW_W-1:0]  row;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               rd_en;
        logic [SLOT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [SLOT_AW-1:0] wr_addr;
        t_entry             wr_data;
    } t_slot_req;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_data;
    } t_key_req;

endpackage
`default_nettype wire

/* hdl/shfi_ram.sv */
// ----------------------------------------------------------------------------
// Salted hash find-or-insert: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module shfi_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hdl/shfi_ctrl.sv */
// ----------------------------------------------------------------------------
// Salted hash find-or-insert: probe controller
// Walks the double-hash probe sequence over the slot and key memories,
// claims empty slots, runs the clearing sweep and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "salted_hash_find_or_insert_macros.svh"
module shfi_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire shfi_pkg::t_op                  i_op,
    input  wire logic [shfi_pkg::HASH_W-1:0]    i_hash,
    input  wire logic [shfi_pkg::ROW_W-1:0]     i_row_index,
    input  wire logic [shfi_pkg::KEY_W-1:0]     i_group_key,
    input  wire logic                           i_cfg_we,
    input  wire logic [shfi_pkg::CAP_LOG2_W-1:0] i_cfg_wdata,
    output shfi_pkg::t_slot_req                 o_slot_req,
    input  wire shfi_pkg::t_entry               i_slot_q,
    output shfi_pkg::t_key_req                  o_key_req,
    input  wire logic [shfi_pkg::KEY_W-1:0]     i_key_q,
    output logic                                o_valid,
    output logic [shfi_pkg::ROW_W-1:0]          o_found_row,
    output logic                                o_inserted,
    output logic                                o_status,
    output logic                                o_resize_advised
);
    import shfi_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_KEY
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [ROW_W-1:0]      r_row;
    logic [KEY_W-1:0]      r_key;
    logic [SALT_W-1:0]     r_salt, n_salt;
    logic [SLOT_AW-1:0]    r_step, n_step;
    logic [SLOT_AW-1:0]    r_slot, n_slot;
    logic [CNT_W-1:0]      r_tries, n_tries;
    logic [ROW_W-1:0]      r_erow, n_erow;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [SLOT_AW-1:0]    r_clr_cnt, n_clr_cnt;
    logic                  r_clr_item, n_clr_item;
    logic [CAP_LOG2_W-1:0] r_cap_log2;
    logic                  r_valid, n_valid;
    logic [ROW_W-1:0]      r_found, n_found;
    logic                  r_ins, n_ins;
    logic                  r_status, n_status;
    logic                  r_resize, n_resize;

    logic [CAP_LOG2_W-1:0] lg_c;
    logic [CNT_W-1:0]      cap;
    logic [SLOT_AW-1:0]    mask;
    logic [SLOT_AW-1:0]    next_slot;
    logic [CNT_W-1:0]      tries_inc;
    logic [CNT_W+1:0]      occ3;
    logic [CNT_W+1:0]      cap2;
    t_slot_req             slot_req;
    t_key_req              key_req;

    always_comb begin
        if (r_cap_log2 < CAP_LOG2_W'(CAP_LOG2_MIN)) begin
            lg_c = CAP_LOG2_W'(CAP_LOG2_MIN);
        end else if (r_cap_log2 > CAP_LOG2_W'(CAP_LOG2_MAX)) begin
            lg_c = CAP_LOG2_W'(CAP_LOG2_MAX);
        end else begin
            lg_c = r_cap_log2;
        end
        cap  = CNT_W'(1) << lg_c;
        mask = SLOT_AW'(cap - CNT_W'(1));
    end

    assign next_slot = (r_slot + r_step) & mask;
    assign tries_inc = r_tries + CNT_W'(1);

    always_comb begin
        n_state    = r_state;
        n_salt     = r_salt;
        n_step     = r_step;
        n_slot     = r_slot;
        n_tries    = r_tries;
        n_erow     = r_erow;
        n_count    = r_count;
        n_clr_cnt  = r_clr_cnt;
        n_clr_item = r_clr_item;
        n_valid    = 1'b0;
        n_found    = r_found;
        n_ins      = r_ins;
        n_status   = r_status;
        slot_req   = '0;
        key_req    = '0;

        case (r_state)
            S_CLEAR: begin
                slot_req.wr_en   = 1'b1;
                slot_req.wr_addr = r_clr_cnt;
                n_clr_cnt        = r_clr_cnt + SLOT_AW'(1);
                if (r_clr_cnt == '1) begin
                    n_state    = S_IDLE;
                    n_clr_item = 1'b0;
                    n_valid    = r_clr_item;
                    n_found    = '0;
                    n_ins      = 1'b0;
                    n_status   = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_salt  = i_hash[SALT_LSB +: SALT_W];
                    n_step  = SLOT_AW'(i_hash[HASH_W-1 -: STEP_W]) | SLOT_AW'(1);
                    n_slot  = i_hash[SLOT_AW-1:0] & mask;
                    n_tries = '0;
                    case (i_op)
                        OP_FIND_INSERT, OP_PLACE: begin
                            slot_req.rd_en   = 1'b1;
                            slot_req.rd_addr = i_hash[SLOT_AW-1:0] & mask;
                            n_state          = S_SLOT;
                        end
                        OP_CLEAR: begin
                            n_state    = S_CLEAR;
                            n_clr_cnt  = '0;
                            n_clr_item = 1'b1;
                            n_count    = '0;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_found  = '0;
                            n_ins    = 1'b0;
                            n_status = 1'b0;
                        end
                    endcase
                end
            end
            S_SLOT, S_KEY: begin
                if (r_state == S_SLOT && !i_slot_q.valid) begin
                    // empty slot: claim it
                    slot_req.wr_en        = 1'b1;
                    slot_req.wr_addr      = r_slot;
                    slot_req.wr_data.valid = 1'b1;
                    slot_req.wr_data.salt = r_salt;
                    slot_req.wr_data.row  = r_row;
                    key_req.wr_en         = 1'b1;
                    key_req.wr_addr       = r_row;
                    key_req.wr_data       = r_key;
                    n_count               = r_count + CNT_W'(1);
                    n_state               = S_IDLE;
                    n_valid               = 1'b1;
                    n_found               = r_row;
                    n_ins                 = 1'b1;
                    n_status              = 1'b0;
                end else if (r_state == S_SLOT && r_op == OP_FIND_INSERT
                             && i_slot_q.salt == r_salt) begin
                    key_req.rd_en   = 1'b1;
                    key_req.rd_addr = i_slot_q.row;
                    n_erow          = i_slot_q.row;
                    n_state         = S_KEY;
                end else if (r_state == S_KEY && i_key_q == r_key) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_found  = r_erow;
                    n_ins    = 1'b0;
                    n_status = 1'b0;
                end else if (tries_inc == cap) begin
                    // every slot probed: table full
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_found  = '0;
                    n_ins    = 1'b0;
                    n_status = 1'b1;
                end else begin
                    slot_req.rd_en   = 1'b1;
                    slot_req.rd_addr = next_slot;
                    n_slot           = next_slot;
                    n_tries          = tries_inc;
                    n_state          = S_SLOT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        occ3     = {2'b00, n_count} + {1'b0, n_count, 1'b0};
        cap2     = {1'b0, cap, 1'b0};
        n_resize = (occ3 >= cap2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_cnt  <= '0;
            r_clr_item <= 1'b0;
            r_count    <= '0;
            r_cap_log2 <= CAP_LOG2_W'(CAP_LOG2_RESET);
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_clr_item <= n_clr_item;
            r_count    <= n_count;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_cap_log2 <= i_cfg_wdata;
            end
            if (r_state == S_IDLE && i_start) begin
                r_op  <= i_op;
                r_row <= i_row_index;
                r_key <= i_group_key;
            end
            r_salt  <= n_salt;
            r_step  <= n_step;
            r_slot  <= n_slot;
            r_tries <= n_tries;
            r_erow  <= n_erow;
            if (n_valid) begin
                r_found  <= n_found;
                r_ins    <= n_ins;
                r_status <= n_status;
                r_resize <= n_resize;
            end
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_slot_req       = slot_req;
    assign o_key_req        = key_req;
    assign o_valid          = r_valid;
    assign o_found_row      = r_found;
    assign o_inserted       = r_ins;
    assign o_status         = r_status;
    assign o_resize_advised = r_resize;

    `SHFI_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
    `SHFI_ASSERT_IMP(a_slot_wr_state, i_clk, i_rst_n, slot_req.wr_en,
        r_state == S_SLOT || r_state == S_CLEAR)
    `SHFI_ASSERT_IMP(a_key_wr_claim, i_clk, i_rst_n, key_req.wr_en,
        slot_req.wr_en && slot_req.wr_data.valid)
    `SHFI_ASSERT_IMP(a_key_after_slot, i_clk, i_rst_n, r_state == S_KEY,
        $past(r_state) == S_SLOT)
    `SHFI_ASSERT_NXT(a_clear_start, i_clk, i_rst_n,
        i_start && r_state == S_IDLE && i_op == OP_CLEAR,
        r_state == S_CLEAR && r_count == '0)
    `SHFI_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(TABLE_SLOTS))

endmodule
`default_nettype wire

/* hdl/salted_hash_find_or_insert.sv */
// ----------------------------------------------------------------------------
// Salted hash find-or-insert
// Open-addressing group-by hash table with salted slots and double hashing.
// ----------------------------------------------------------------------------
// Channel  | Handshake                 | Payload
// input    | start (in), busy (out)    | i_op, i_hash, i_row_index, i_group_key
// result   | o_valid strobe (out)      | o_found_row, o_inserted, o_status,
//          |                           | o_resize_advised
// config   | i_cfg_we (in)             | i_cfg_wdata (capacity_log2)
//
// One probe per cycle from the slot memory, except that a salt hit first reads the
// key memory (state S_KEY) before the walk goes on. The o_valid strobe is registered
// from the state that ends the item. Reset and the clear op sweep all 4096 slots,
// one per cycle; busy is high for the sweep. A new item is taken while the previous
// result is shown.
// ----------------------------------------------------------------------------
`default_nettype none
module salted_hash_find_or_insert (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [shfi_pkg::OP_W-1:0]       i_op,
    input  wire logic [shfi_pkg::HASH_W-1:0]     i_hash,
    input  wire logic [shfi_pkg::ROW_W-1:0]      i_row_index,
    input  wire logic [shfi_pkg::KEY_W-1:0]      i_group_key,
    input  wire logic                            i_cfg_we,
    input  wire logic [shfi_pkg::CAP_LOG2_W-1:0] i_cfg_wdata,
    output logic                                 o_valid,
    output logic [shfi_pkg::ROW_W-1:0]           o_found_row,
    output logic                                 o_inserted,
    output logic                                 o_status,
    output logic                                 o_resize_advised
);
    import shfi_pkg::*;

    t_slot_req        slot_req;
    t_key_req         key_req;
    logic [ENTRY_W-1:0] slot_q;
    logic [KEY_W-1:0] key_q;

    shfi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_op            (t_op'(i_op)),
        .i_hash          (i_hash),
        .i_row_index     (i_row_index),
        .i_group_key     (i_group_key),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_slot_req      (slot_req),
        .i_slot_q        (t_entry'(slot_q)),
        .o_key_req       (key_req),
        .i_key_q         (key_q),
        .o_valid         (o_valid),
        .o_found_row     (o_found_row),
        .o_inserted      (o_inserted),
        .o_status        (o_status),
        .o_resize_advised(o_resize_advised)
    );

    shfi_ram #(
        .WIDTH(ENTRY_W),
        .AW   (SLOT_AW)
    ) u_slot_ram (
        .i_clk    (i_clk),
        .i_rd_en  (slot_req.rd_en),
        .i_rd_addr(slot_req.rd_addr),
        .o_rd_data(slot_q),
        .i_wr_en  (slot_req.wr_en),
        .i_wr_addr(slot_req.wr_addr),
        .i_wr_data(slot_req.wr_data)
    );

    shfi_ram #(
        .WIDTH(KEY_W),
        .AW   (ROW_W)
    ) u_key_ram (
        .i_clk    (i_clk),
        .i_rd_en  (key_req.rd_en),
        .i_rd_addr(key_req.rd_addr),
        .o_rd_data(key_q),
        .i_wr_en  (key_req.wr_en),
        .i_wr_addr(key_req.wr_addr),
        .i_wr_data(key_req.wr_data)
    );

endmodule
`default_nettype wire

/* tb/tb_salted_hash_find_or_insert.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Salted hash find-or-insert: testbench
// Drives find/insert, place, clear and unused-op items across many capacity
// settings and checks every result against an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb_salted_hash_find_or_insert;
    import shfi_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [ROW_W-1:0] found_row;
        logic             inserted;
        logic             status;
        logic             resize_advised;
    } t_group_result;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
    } t_group_ref;

    class t_group_tracker;
        t_entry                  slot_tbl [TABLE_SLOTS];
        logic [KEY_W-1:0]        key_tbl [MAX_ROWS];
        int unsigned             occupied;
        logic [CAP_LOG2_W-1:0]   cap_log2;
        t_group_result           expected_q [$];
        int                      mismatches;

        function new();
            foreach (slot_tbl[i]) slot_tbl[i] = '0;
            foreach (key_tbl[i]) key_tbl[i] = '0;
            occupied = 0;
            cap_log2 = CAP_LOG2_W'(CAP_LOG2_RESET);
            mismatches = 0;
        endfunction

        function int unsigned capacity();
            int unsigned lg;
            lg = cap_log2;
            if (lg < CAP_LOG2_MIN) lg = CAP_LOG2_MIN;
            if (lg > CAP_LOG2_MAX) lg = CAP_LOG2_MAX;
            return 1 << lg;
        endfunction

        function void note_item(t_op op, logic [HASH_W-1:0] hash, logic [ROW_W-1:0] row,
                                logic [KEY_W-1:0] key);
            t_group_result     r;
            int unsigned       cap;
            int unsigned       mask;
            int unsigned       slot;
            int unsigned       step;
            int unsigned       tries;
            logic [SALT_W-1:0] salt;
            bit                done;
            t_entry            e;
            r = '0;
            case (op)
                OP_CLEAR: begin
                    foreach (slot_tbl[i]) slot_tbl[i] = '0;
                    occupied = 0;
                end
                OP_FIND_INSERT, OP_PLACE: begin
                    cap = capacity();
                    mask = cap - 1;
                    salt = hash[SALT_LSB +: SALT_W];
                    step = {27'd0, hash[HASH_W-1:STEP_LSB]} | 1;
                    slot = hash[31:0] & mask;
                    done = 0;
                    for (tries = 0; tries < cap && !done; tries++) begin
                        e = slot_tbl[slot];
                        if (!e.valid) begin
                            slot_tbl[slot] = '{valid: 1'b1, salt: salt, row: row};
                            key_tbl[row] = key;
                            occupied++;
                            r.found_row = row;
                            r.inserted = 1'b1;
                            done = 1;
                        end else if (op == OP_FIND_INSERT && e.salt == salt
                                     && key_tbl[e.row] == key) begin
                            r.found_row = e.row;
                            done = 1;
                        end
                        if (!done) slot = (slot + step) & mask;
                    end
                    if (!done) r.status = 1'b1;
                end
                default: ;
            endcase
            r.resize_advised = (occupied * 3 >= capacity() * 2);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_group_result got);
            t_group_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row=%0d ins=%0b st=%0b rsz=%0b",
                             got.found_row, got.inserted, got.status, got.resize_advised);
                return;
            end
            want = expected_q.pop_front();
            if (got.found_row !== want.found_row || got.inserted !== want.inserted
                || got.status !== want.status
                || got.resize_advised !== want.resize_advised) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp row=%0d ins=%0b st=%0b rsz=%0b, ",
                              "got row=%0d ins=%0b st=%0b rsz=%0b"},
                             want.found_row, want.inserted, want.status, want.resize_advised,
                             got.found_row, got.inserted, got.status, got.resize_advised);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       i_op;
    logic [HASH_W-1:0]     i_hash;
    logic [ROW_W-1:0]      i_row_index;
    logic [KEY_W-1:0]      i_group_key;
    logic                  i_cfg_we;
    logic [CAP_LOG2_W-1:0] i_cfg_wdata;
    logic                  o_valid;
    logic [ROW_W-1:0]      o_found_row;
    logic                  o_inserted;
    logic                  o_status;
    logic                  o_resize_advised;

    t_group_tracker     grp_tracker;
    t_group_ref         recent_groups [$];
    bit                 start_high;
    int                 cycle_count;

    salted_hash_find_or_insert dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_hash           (i_hash),
        .i_row_index      (i_row_index),
        .i_group_key      (i_group_key),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_found_row      (o_found_row),
        .o_inserted       (o_inserted),
        .o_status         (o_status),
        .o_resize_advised (o_resize_advised)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** salted_hash_find_or_insert: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            grp_tracker.check_result('{found_row: o_found_row, inserted: o_inserted,
                                       status: o_status, resize_advised: o_resize_advised});
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // start stays high across back-to-back items
    task automatic send_item(input t_op op, input logic [HASH_W-1:0] hash,
                             input logic [ROW_W-1:0] row, input logic [KEY_W-1:0] key);
        start <= 1'b1;
        i_op <= op;
        i_hash <= hash;
        i_row_index <= row;
        i_group_key <= key;
        start_high = 1;
        do @(posedge i_clk); while (busy);
        grp_tracker.note_item(op, hash, row, key);
    endtask

    // caller must let at least one edge pass afterwards
    task automatic lower_start();
        if (start_high) begin
            start <= 1'b0;
            start_high = 0;
        end
    endtask

    task automatic drain();
        lower_start();
        do @(posedge i_clk); while (grp_tracker.expected_q.size() != 0 || busy);
    endtask

    task automatic write_capacity(input logic [CAP_LOG2_W-1:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        grp_tracker.cap_log2 = value;
    endtask

    task automatic send_random_item();
        int                pick;
        int                idx;
        t_group_ref        g;
        logic [HASH_W-1:0] hash;
        logic [KEY_W-1:0]  key;
        logic [ROW_W-1:0]  row;
        pick = $urandom_range(0, 99);
        row = ROW_W'($urandom);
        hash = rand64();
        key = rand64();
        if (recent_groups.size() != 0) begin
            idx = $urandom_range(0, recent_groups.size() - 1);
            g = recent_groups[idx];
        end else begin
            g = '{hash: hash, key: key};
        end
        if (pick < 2) begin
            send_item(OP_CLEAR, hash, row, key);
        end else if (pick < 5) begin
            send_item(OP_NONE, hash, row, key);
        end else if (pick < 13) begin
            if ($urandom_range(0, 1) == 0) begin
                hash = g.hash;
                key = g.key;
            end
            send_item(OP_PLACE, hash, row, key);
        end else if (pick < 45) begin
            send_item(OP_FIND_INSERT, g.hash, row, g.key);
        end else if (pick < 55) begin
            send_item(OP_FIND_INSERT, g.hash, row, key);
            recent_groups.push_back('{hash: g.hash, key: key});
        end else if (pick < 62) begin
            hash[SALT_LSB +: SALT_W] = g.hash[SALT_LSB +: SALT_W];
            send_item(OP_FIND_INSERT, hash, row, key);
            recent_groups.push_back('{hash: hash, key: key});
        end else begin
            send_item(OP_FIND_INSERT, hash, row, key);
            recent_groups.push_back('{hash: hash, key: key});
        end
        if (recent_groups.size() > 24) void'(recent_groups.pop_front());
    endtask

    initial begin
        logic [CAP_LOG2_W-1:0] cap_plan [16];
        int n_items;
        int burst_left;
        int gap;
        cap_plan = '{5, 6, 13, 8, 4, 10, 7, 12, 1, 9, 11, 14, 2, 3, 5, 6};
        grp_tracker = new();
        start_high = 0;
        cycle_count = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_op <= OP_FIND_INSERT;
        i_hash <= '0;
        i_row_index <= '0;
        i_group_key <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every op, salt hit with key miss, clear
        send_item(OP_FIND_INSERT, 64'h0, 12'h000, 64'h0);
        send_item(OP_FIND_INSERT, 64'h0, 12'h123, 64'h0);
        send_item(OP_FIND_INSERT, '1, 12'hFFF, '1);
        send_item(OP_FIND_INSERT, '1, 12'h800, 64'h0);
        send_item(OP_PLACE, 64'h0, 12'h005, 64'h0);
        send_item(OP_FIND_INSERT, 64'h0, 12'h777, 64'h0);
        send_item(OP_NONE, rand64(), 12'hABC, rand64());
        send_item(OP_CLEAR, rand64(), 12'h555, rand64());
        send_item(OP_FIND_INSERT, 64'h0, 12'h001, 64'h0);
        // below- and above-range register values, table kept across capacity change
        write_capacity(4'd0);
        send_item(OP_FIND_INSERT, 64'h20, 12'h002, 64'h1);
        send_item(OP_FIND_INSERT, 64'h20, 12'h003, 64'h1);
        write_capacity(4'd15);
        send_item(OP_FIND_INSERT, 64'h20, 12'h004, 64'h1);
        send_item(OP_PLACE, '1, 12'hFFE, '1);
        lower_start();
        @(posedge i_clk);
        send_item(OP_CLEAR, 64'h0, 12'h000, 64'h0);

        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            n_items = $urandom_range(30, 50);
            burst_left = 0;
            for (int i = 0; i < n_items; i++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        lower_start();
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 20);
                end
                if ($urandom_range(0, 49) == 0) drain();
                send_random_item();
                burst_left--;
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (grp_tracker.mismatches == 0 && grp_tracker.expected_q.size() == 0) begin
            $display("** salted_hash_find_or_insert: PASSED **");
        end else begin
            $display("** salted_hash_find_or_insert: FAILED **");
        end
        $finish;
    end

endmodule
